// File: src/svpd_pkg.sv
// Shared constants, codes and tables for the space vector PWM duty pipeline.
`timescale 1ns / 1ps

package svpd_pkg;

	localparam int ITERS = 16;

	// Arctangent table in 2^24 counts per turn.
	localparam logic [21:0] ATAN_TAB [ITERS] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
		22'd166669, 22'd83416, 22'd41718, 22'd20860,
		22'd10430, 22'd5215, 22'd2608, 22'd1304,
		22'd652, 22'd326, 22'd163, 22'd81
	};

	localparam logic [15:0] MOD_CAP_Q16 = 16'd37814;
	localparam logic [16:0] SQRT3_Q16 = 17'd113512;
	localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
	// ceil(2^25 / 3), exact for the operand range of the sector angle.
	localparam logic [23:0] RECIP3_Q25 = 24'd11184811;

	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [1:0] REG_SUPPLY = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	typedef enum logic [2:0] {
		SEC_1 = 3'd0,
		SEC_2 = 3'd1,
		SEC_3 = 3'd2,
		SEC_4 = 3'd3,
		SEC_5 = 3'd4,
		SEC_6 = 3'd5
	} sector_t;

endpackage

// File: src/svpwm_phase_duty_core.sv
// Throughput: one command per cycle; the path is a fixed-depth pipeline set by the
// 32-step square root, the 16-step divide and the two 16-step CORDIC units.
// While a result waits on a stalled output, the whole pipeline holds.
// Reset clears all valid bits and loads limit 0, supply 3072 and period 1000.
`timescale 1ns / 1ps

module svpwm_phase_duty_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] volt_q,
	input  logic signed [15:0] volt_d,
	input  logic [15:0] elec_angle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] compare_ch1,
	output logic [15:0] compare_ch2,
	output logic [15:0] compare_ch3
);
	import svpd_pkg::*;

	localparam logic [15:0] LIMIT_RST = 16'd0;
	localparam logic [15:0] SUPPLY_RST = 16'd3072;
	localparam logic [15:0] PERIOD_RST = 16'd1000;
	localparam logic [17:0] PHASE_CAP = 18'd131072;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [63:0] RND_Q46 = 64'd1 << 45;

	logic [15:0] limit_q;
	logic [15:0] supply_q;
	logic [15:0] period_q;

	logic en;

	logic               v_s1;
	logic signed [15:0] q_s1;
	logic signed [15:0] d_s1;
	logic [15:0]        ang_s1;

	logic               v_s2;
	logic [31:0]        sum_s2;
	logic signed [15:0] q_s2;
	logic signed [15:0] d_s2;
	logic [15:0]        ang_s2;

	logic        mag_valid;
	logic [15:0] mag_m;
	logic [47:0] mag_pay;

	logic        at_valid;
	logic [15:0] at_off;
	logic [31:0] at_pay;

	logic        v_s3;
	logic [23:0] na_s3;
	logic [23:0] nb_s3;
	logic [2:0]  sec_s3;
	logic [15:0] m_s3;

	logic        v_s4;
	logic [21:0] tga_s4;
	logic [21:0] tgb_s4;
	logic [2:0]  sec_s4;
	logic [15:0] m_s4;

	logic        sn_valid;
	logic [30:0] sn_a;
	logic [30:0] sn_b;
	logic [18:0] sn_pay;

	logic        v_s5;
	logic [31:0] c_s5;
	logic [30:0] sa_s5;
	logic [30:0] sb_s5;
	logic [2:0]  sec_s5;

	logic        v_s6;
	logic [16:0] t1_s6;
	logic [16:0] t2_s6;
	logic [2:0]  sec_s6;

	logic        v_s7;
	logic [17:0] pa_s7;
	logic [17:0] pb_s7;
	logic [17:0] pc_s7;

	logic        v_s8;
	logic [15:0] cmp1_s8;
	logic [15:0] cmp2_s8;
	logic [15:0] cmp3_s8;

	// The pipeline moves unless a finished result is held by the consumer.
	assign en        = !(v_s8 && out_stall);
	assign in_stall  = v_s8 && out_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RST;
			supply_q <= SUPPLY_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT:  limit_q  <= cfg_data;
				REG_SUPPLY: supply_q <= cfg_data;
				REG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: clamp both commands to the limit, which never exceeds the supply.
	logic [15:0]        lim;
	logic signed [17:0] lim_p;
	logic signed [17:0] lim_n;
	logic signed [17:0] q_ext;
	logic signed [17:0] d_ext;
	logic signed [17:0] q_cl;
	logic signed [17:0] d_cl;

	assign lim   = (limit_q < supply_q) ? limit_q : supply_q;
	assign lim_p = $signed({2'b00, lim});
	assign lim_n = -lim_p;
	assign q_ext = 18'(volt_q);
	assign d_ext = 18'(volt_d);
	assign q_cl  = (q_ext > lim_p) ? lim_p : ((q_ext < lim_n) ? lim_n : q_ext);
	assign d_cl  = (d_ext > lim_p) ? lim_p : ((d_ext < lim_n) ? lim_n : d_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= at_valid;
			v_s4 <= v_s3;
			v_s5 <= sn_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= q_cl[15:0];
			d_s1   <= d_cl[15:0];
			ang_s1 <= elec_angle;
		end
	end

	// Stage 2: squared length of the command vector.
	logic signed [31:0] qq;
	logic signed [31:0] dd;

	assign qq = q_s1 * q_s1;
	assign dd = d_s1 * d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= $unsigned(qq) + $unsigned(dd);
			q_s2   <= q_s1;
			d_s2   <= d_s1;
			ang_s2 <= ang_s1;
		end
	end

	svpd_mag #(
		.PW(48)
	) u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.sum      (sum_s2),
		.supply   (supply_q),
		.in_pay   ({q_s2, d_s2, ang_s2}),
		.out_valid(mag_valid),
		.m        (mag_m),
		.out_pay  (mag_pay)
	);

	svpd_atan #(
		.PW(32)
	) u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mag_valid),
		.q        ($signed(mag_pay[47:32])),
		.d        ($signed(mag_pay[31:16])),
		.in_pay   ({mag_m, mag_pay[15:0]}),
		.out_valid(at_valid),
		.off      (at_off),
		.out_pay  (at_pay)
	);

	// Stage 3: field angle, sector and the angle operands, halved ahead of the divide by three.
	logic [15:0] theta;
	logic [18:0] p6;
	logic [15:0] r;
	logic [16:0] r_rem;
	logic [24:0] na;
	logic [24:0] nb;

	assign theta = at_pay[15:0] + at_off;
	assign p6    = ({3'b000, theta} << 2) + ({3'b000, theta} << 1);
	assign r     = p6[15:0];
	assign r_rem = ONE_Q16 - {1'b0, r};
	assign na    = {r_rem, 8'd0} + 25'd3;
	assign nb    = {1'b0, r, 8'd0} + 25'd3;

	always_ff @(posedge clk) begin
		if (en) begin
			na_s3  <= na[24:1];
			nb_s3  <= nb[24:1];
			sec_s3 <= p6[18:16];
			m_s3   <= at_pay[31:16];
		end
	end

	// Stage 4: divide by three with a reciprocal multiply.
	logic [47:0] pa3;
	logic [47:0] pb3;

	assign pa3 = na_s3 * RECIP3_Q25;
	assign pb3 = nb_s3 * RECIP3_Q25;

	always_ff @(posedge clk) begin
		if (en) begin
			tga_s4 <= pa3[46:25];
			tgb_s4 <= pb3[46:25];
			sec_s4 <= sec_s3;
			m_s4   <= m_s3;
		end
	end

	svpd_sin #(
		.PW(19)
	) u_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.tgt_a    (tga_s4),
		.tgt_b    (tgb_s4),
		.in_pay   ({sec_s4, m_s4}),
		.out_valid(sn_valid),
		.sin_a    (sn_a),
		.sin_b    (sn_b),
		.out_pay  (sn_pay)
	);

	// Stage 5: sqrt3 times the modulation index.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s5   <= 32'(SQRT3_Q16 * sn_pay[15:0]);
			sa_s5  <= sn_a;
			sb_s5  <= sn_b;
			sec_s5 <= sn_pay[18:16];
		end
	end

	// Stage 6: dwell times T1 and T2 in Q16, rounded.
	logic [63:0] p1;
	logic [63:0] p2;

	assign p1 = {32'd0, c_s5} * {33'd0, sa_s5} + RND_Q46;
	assign p2 = {32'd0, c_s5} * {33'd0, sb_s5} + RND_Q46;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s6  <= p1[62:46];
			t2_s6  <= p2[62:46];
			sec_s6 <= sec_s5;
		end
	end

	// Stage 7: zero-vector time and the three phase times in Q17.
	logic [17:0] t12;
	logic [19:0] t0;
	logic [19:0] t1x;
	logic [19:0] t2x;
	logic [19:0] ta;
	logic [19:0] tb;
	logic [19:0] tc;

	assign t12 = {1'b0, t1_s6} + {1'b0, t2_s6};
	assign t0  = (t12 < {1'b0, ONE_Q16}) ? 20'({1'b0, ONE_Q16} - t12) : 20'd0;
	assign t1x = {2'b00, t1_s6, 1'b0};
	assign t2x = {2'b00, t2_s6, 1'b0};

	always_comb begin
		case (sec_s6)
			SEC_1: begin
				ta = t1x + t2x + t0;
				tb = t2x + t0;
				tc = t0;
			end
			SEC_2: begin
				ta = t1x + t0;
				tb = t1x + t2x + t0;
				tc = t0;
			end
			SEC_3: begin
				ta = t0;
				tb = t1x + t2x + t0;
				tc = t2x + t0;
			end
			SEC_4: begin
				ta = t0;
				tb = t1x + t0;
				tc = t1x + t2x + t0;
			end
			SEC_5: begin
				ta = t2x + t0;
				tb = t0;
				tc = t1x + t2x + t0;
			end
			default: begin
				ta = t1x + t2x + t0;
				tb = t0;
				tc = t1x + t0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s7 <= (ta > {2'b00, PHASE_CAP}) ? PHASE_CAP : ta[17:0];
			pb_s7 <= (tb > {2'b00, PHASE_CAP}) ? PHASE_CAP : tb[17:0];
			pc_s7 <= (tc > {2'b00, PHASE_CAP}) ? PHASE_CAP : tc[17:0];
		end
	end

	// Stage 8: scale by the timer period into the output register.
	logic [33:0] ca;
	logic [33:0] cb;
	logic [33:0] cc;

	assign ca = pa_s7 * period_q;
	assign cb = pb_s7 * period_q;
	assign cc = pc_s7 * period_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cmp1_s8 <= cc[32:17];
			cmp2_s8 <= cb[32:17];
			cmp3_s8 <= ca[32:17];
		end
	end

	assign out_valid   = v_s8;
	assign compare_ch1 = cmp1_s8;
	assign compare_ch2 = cmp2_s8;
	assign compare_ch3 = cmp3_s8;

endmodule

// File: src/svpd_mag.sv
// Modulation index: pipelined square root followed by a pipelined divide by supply.
`timescale 1ns / 1ps

module svpd_mag #(
	parameter int PW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   sum,
	input  logic [15:0]   supply,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [15:0]   m,
	output logic [PW-1:0] out_pay
);
	import svpd_pkg::*;

	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 16;

	logic          sq_v_s   [SQ_STEPS+1];
	logic [33:0]   sq_rem_s [SQ_STEPS+1];
	logic [31:0]   sq_res_s [SQ_STEPS+1];
	logic [31:0]   sq_bits_s[SQ_STEPS+1];
	logic [PW-1:0] sq_pay_s [SQ_STEPS+1];

	logic          dv_v_s   [DIV_STEPS+1];
	logic [15:0]   dv_rem_s [DIV_STEPS+1];
	logic [15:0]   dv_low_s [DIV_STEPS+1];
	logic [15:0]   dv_quo_s [DIV_STEPS+1];
	logic          dv_sat_s [DIV_STEPS+1];
	logic [PW-1:0] dv_pay_s [DIV_STEPS+1];

	logic [15:0] s_eff;

	assign s_eff = (supply == 16'd0) ? 16'd1 : supply;

	// The radicand is sum * 2^32, so the low sixteen bit pairs shift in as zeros.
	assign sq_v_s[0]    = in_valid;
	assign sq_rem_s[0]  = '0;
	assign sq_res_s[0]  = '0;
	assign sq_bits_s[0] = sum;
	assign sq_pay_s[0]  = in_pay;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic        ge;

		assign rem_sh = {sq_rem_s[k], sq_bits_s[k][31:30]};
		assign trial  = {2'b00, sq_res_s[k], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k+1]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
				sq_res_s[k+1]  <= {sq_res_s[k][30:0], ge};
				sq_bits_s[k+1] <= {sq_bits_s[k][29:0], 2'b00};
				sq_pay_s[k+1]  <= sq_pay_s[k];
			end
		end
	end

	// When the root's upper half reaches the supply the quotient exceeds 16 bits.
	assign dv_v_s[0]   = sq_v_s[SQ_STEPS];
	assign dv_rem_s[0] = sq_res_s[SQ_STEPS][31:16];
	assign dv_low_s[0] = sq_res_s[SQ_STEPS][15:0];
	assign dv_quo_s[0] = '0;
	assign dv_sat_s[0] = (sq_res_s[SQ_STEPS][31:16] >= s_eff);
	assign dv_pay_s[0] = sq_pay_s[SQ_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [16:0] t;
		logic        ge;

		assign t  = {dv_rem_s[j], dv_low_s[j][15]};
		assign ge = (t >= {1'b0, s_eff});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= ge ? 16'(t - {1'b0, s_eff}) : t[15:0];
				dv_low_s[j+1] <= {dv_low_s[j][14:0], 1'b0};
				dv_quo_s[j+1] <= {dv_quo_s[j][14:0], ge};
				dv_sat_s[j+1] <= dv_sat_s[j];
				dv_pay_s[j+1] <= dv_pay_s[j];
			end
		end
	end

	assign out_valid = dv_v_s[DIV_STEPS];
	assign out_pay   = dv_pay_s[DIV_STEPS];
	assign m = (dv_sat_s[DIV_STEPS] || (dv_quo_s[DIV_STEPS] > MOD_CAP_Q16)) ?
		MOD_CAP_Q16 : dv_quo_s[DIV_STEPS];

endmodule

// File: src/svpd_atan.sv
// Angle offset of the voltage vector: pipelined vectoring CORDIC for atan2(q, d).
`timescale 1ns / 1ps

module svpd_atan #(
	parameter int PW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [15:0] q,
	input  logic signed [15:0] d,
	input  logic [PW-1:0]      in_pay,
	output logic               out_valid,
	output logic [15:0]        off,
	output logic [PW-1:0]      out_pay
);
	import svpd_pkg::*;

	localparam logic [15:0] QTR_TURN = 16'd16384;
	localparam logic [15:0] THREE_QTR_TURN = 16'd49152;
	localparam logic signed [25:0] HALF_TURN_ACC = 26'sd8388608;

	logic                v_s    [ITERS+1];
	logic signed [35:0]  x_s    [ITERS+1];
	logic signed [35:0]  y_s    [ITERS+1];
	logic signed [25:0]  acc_s  [ITERS+1];
	logic                dzero_s[ITERS+1];
	logic                qneg_s [ITERS+1];
	logic [PW-1:0]       pay_s  [ITERS+1];

	logic signed [35:0] x_in;
	logic signed [35:0] y_in;
	logic [25:0]        acc_rnd;

	assign x_in = {{4{d[15]}}, d, 16'd0};
	assign y_in = {{4{q[15]}}, q, 16'd0};

	// A vector in the left half plane is turned by half a turn first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]     <= d[15] ? -x_in : x_in;
			y_s[0]     <= d[15] ? -y_in : y_in;
			acc_s[0]   <= d[15] ? HALF_TURN_ACC : '0;
			dzero_s[0] <= (d == 16'sd0);
			qneg_s[0]  <= q[15];
			pay_s[0]   <= in_pay;
		end
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_it
		logic signed [35:0] xs;
		logic signed [35:0] ys;
		logic signed [25:0] step;
		logic               ypos;

		assign xs   = x_s[i] >>> i;
		assign ys   = y_s[i] >>> i;
		assign step = $signed({4'b0000, ATAN_TAB[i]});
		assign ypos = !y_s[i][35] && (y_s[i] != 36'sd0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]     <= ypos ? x_s[i] + ys : x_s[i] - ys;
				y_s[i+1]     <= ypos ? y_s[i] - xs : y_s[i] + xs;
				acc_s[i+1]   <= ypos ? acc_s[i] + step : acc_s[i] - step;
				dzero_s[i+1] <= dzero_s[i];
				qneg_s[i+1]  <= qneg_s[i];
				pay_s[i+1]   <= pay_s[i];
			end
		end
	end

	assign acc_rnd   = acc_s[ITERS] + 26'sd128;
	assign out_valid = v_s[ITERS];
	assign out_pay   = pay_s[ITERS];
	assign off = dzero_s[ITERS] ? (qneg_s[ITERS] ? THREE_QTR_TURN : QTR_TURN) :
		acc_rnd[23:8];

endmodule

// File: src/svpd_sin.sv
// Sines of the two sector angles: two pipelined rotation CORDIC lanes side by side.
`timescale 1ns / 1ps

module svpd_sin #(
	parameter int PW = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [21:0]   tgt_a,
	input  logic [21:0]   tgt_b,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [30:0]   sin_a,
	output logic [30:0]   sin_b,
	output logic [PW-1:0] out_pay
);
	import svpd_pkg::*;

	localparam int LANES = 2;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	logic               v_s  [ITERS+1];
	logic [PW-1:0]      pay_s[ITERS+1];
	logic signed [33:0] x_s  [LANES][ITERS+1];
	logic signed [33:0] y_s  [LANES][ITERS+1];
	logic signed [25:0] z_s  [LANES][ITERS+1];
	logic [30:0]        sin_out[LANES];

	assign v_s[0]   = in_valid;
	assign pay_s[0] = in_pay;
	assign z_s[0][0] = $signed({4'b0000, tgt_a});
	assign z_s[1][0] = $signed({4'b0000, tgt_b});

	for (genvar i = 0; i < ITERS; i++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_s[i+1] <= pay_s[i];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [33:0] y_fin;

		assign x_s[l][0] = CORDIC_K_Q30;
		assign y_s[l][0] = '0;

		for (genvar i = 0; i < ITERS; i++) begin : g_it
			logic signed [33:0] xs;
			logic signed [33:0] ys;
			logic signed [25:0] step;
			logic               zpos;

			assign xs   = x_s[l][i] >>> i;
			assign ys   = y_s[l][i] >>> i;
			assign step = $signed({4'b0000, ATAN_TAB[i]});
			assign zpos = !z_s[l][i][25];

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[l][i+1] <= zpos ? x_s[l][i] - ys : x_s[l][i] + ys;
					y_s[l][i+1] <= zpos ? y_s[l][i] + xs : y_s[l][i] - xs;
					z_s[l][i+1] <= zpos ? z_s[l][i] - step : z_s[l][i] + step;
				end
			end
		end

		// The result is held to the range zero to one.
		assign y_fin = y_s[l][ITERS];
		assign sin_out[l] = y_fin[33] ? 31'd0 :
			(y_fin > ONE_Q30) ? ONE_Q30[30:0] : y_fin[30:0];
	end

	assign out_valid = v_s[ITERS];
	assign out_pay   = pay_s[ITERS];
	assign sin_a     = sin_out[0];
	assign sin_b     = sin_out[1];

endmodule

// File: verif/svpd_checker.sv
// Checker for the SVPWM duty core: predicts compares per command and scores results.
`timescale 1ns / 1ps

module svpd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] volt_q,
	input  logic signed [15:0] volt_d,
	input  logic [15:0]        elec_angle,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        compare_ch1,
	input  logic [15:0]        compare_ch2,
	input  logic [15:0]        compare_ch3,
	output int                 fail_count,
	output int                 pending
);
	import svpd_pkg::*;

	typedef struct packed {
		logic [15:0] ch1;
		logic [15:0] ch2;
		logic [15:0] ch3;
	} compares_t;

	logic [15:0] lim_reg;
	logic [15:0] supply_reg;
	logic [15:0] period_reg;
	compares_t   duty_queue[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC; the accumulator runs at 2^24 counts per turn.
	function automatic logic [15:0] vector_angle(longint y, longint x);
		longint acc;
		longint xs;
		longint ys;
		logic [31:0] rnd;
		acc = 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 8388608;
		end
		for (int i = 0; i < ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + longint'(ATAN_TAB[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - longint'(ATAN_TAB[i]);
			end
		end
		rnd = acc[31:0] + 32'd128;
		return rnd[23:8];
	endfunction

	function automatic longint unsigned rotate_sine(longint target);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = longint'(CORDIC_K_Q30);
		y = 0;
		z = target;
		for (int i = 0; i < ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ATAN_TAB[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ATAN_TAB[i]);
			end
		end
		if (y < 0)
			y = 0;
		if (y > (longint'(1) << 30))
			y = longint'(1) << 30;
		return longint'(y);
	endfunction

	function automatic logic [15:0] scale_period(longint unsigned t17);
		longint unsigned prod;
		if (t17 > (64'd1 << 17))
			t17 = 64'd1 << 17;
		prod = (t17 * period_reg) >> 17;
		return prod[15:0];
	endfunction

	function automatic compares_t predict_compares(logic signed [15:0] q_in,
			logic signed [15:0] d_in, logic [15:0] ang);
		longint q;
		longint d;
		longint lim;
		longint unsigned s;
		longint unsigned m;
		longint unsigned sa;
		longint unsigned sb;
		longint unsigned t1;
		longint unsigned t2;
		longint unsigned t0;
		longint unsigned ta;
		longint unsigned tb;
		longint unsigned tc;
		longint unsigned sum;
		logic [15:0] off;
		logic [15:0] theta;
		logic [31:0] six_theta;
		logic [31:0] r;
		sector_t sec;
		compares_t res;
		q = q_in;
		d = d_in;
		lim = (lim_reg < supply_reg) ? lim_reg : supply_reg;
		s = (supply_reg != 0) ? supply_reg : 1;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		if (d > lim) d = lim;
		if (d < -lim) d = -lim;

		sum = longint'(q * q) + longint'(d * d);
		m = int_sqrt(sum << 32) / s;
		if (m > MOD_CAP_Q16)
			m = MOD_CAP_Q16;

		if (d != 0)
			off = vector_angle(q, d);
		else
			off = (q < 0) ? 16'd49152 : 16'd16384;
		theta = ang + off;

		six_theta = {16'd0, theta} * 32'd6;
		sec = sector_t'(six_theta[18:16]);
		r = {16'd0, six_theta[15:0]};
		sa = rotate_sine(longint'(((32'd65536 - r) * 32'd256 + 32'd3) / 32'd6));
		sb = rotate_sine(longint'((r * 32'd256 + 32'd3) / 32'd6));

		t1 = (SQRT3_Q16 * sa * m + (64'd1 << 45)) >> 46;
		t2 = (SQRT3_Q16 * sb * m + (64'd1 << 45)) >> 46;
		t0 = (t1 + t2 < 65536) ? 65536 - t1 - t2 : 0;
		t1 = t1 * 2;
		t2 = t2 * 2;

		case (sec)
			SEC_1: begin ta = t1 + t2 + t0; tb = t2 + t0; tc = t0; end
			SEC_2: begin ta = t1 + t0; tb = t1 + t2 + t0; tc = t0; end
			SEC_3: begin ta = t0; tb = t1 + t2 + t0; tc = t2 + t0; end
			SEC_4: begin ta = t0; tb = t1 + t0; tc = t1 + t2 + t0; end
			SEC_5: begin ta = t2 + t0; tb = t0; tc = t1 + t2 + t0; end
			default: begin ta = t1 + t2 + t0; tb = t0; tc = t1 + t0; end
		endcase

		res.ch1 = scale_period(tc);
		res.ch2 = scale_period(tb);
		res.ch3 = scale_period(ta);
		return res;
	endfunction

	assign pending = duty_queue.size();

	always @(posedge clk or negedge arst_n) begin
		compares_t exp_c;
		if (!arst_n) begin
			lim_reg <= 16'd0;
			supply_reg <= 16'd3072;
			period_reg <= 16'd1000;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LIMIT:  lim_reg <= cfg_data;
					REG_SUPPLY: supply_reg <= cfg_data;
					REG_PERIOD: period_reg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				duty_queue.push_back(predict_compares(volt_q, volt_d, elec_angle));
			if (out_valid && !out_stall) begin
				if (duty_queue.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result %0d %0d %0d",
							compare_ch1, compare_ch2, compare_ch3);
					fail_count <= fail_count + 1;
				end else begin
					exp_c = duty_queue.pop_front();
					if (exp_c.ch1 !== compare_ch1 || exp_c.ch2 !== compare_ch2 ||
							exp_c.ch3 !== compare_ch3) begin
						if (fail_count < 10)
							$display("ERROR: compares expected %0d %0d %0d, got %0d %0d %0d",
								exp_c.ch1, exp_c.ch2, exp_c.ch3,
								compare_ch1, compare_ch2, compare_ch3);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: verif/tb_top.sv
// Top of the SVPWM duty core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import svpd_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_LIMIT;
	logic [15:0]        cfg_data = 16'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] volt_q = 16'sd0;
	logic signed [15:0] volt_d = 16'sd0;
	logic [15:0]        elec_angle = 16'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        compare_ch1;
	logic [15:0]        compare_ch2;
	logic [15:0]        compare_ch3;
	int                 fail_count;
	int                 pending;
	int                 cycle_count = 0;
	int                 stall_mode = 0;
	logic [15:0]        cur_limit = 16'd0;

	always #5 clk = ~clk;

	svpwm_phase_duty_core dut (.*);

	svpd_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver stall pattern, drawn at random from four modes.
	always @(posedge clk) begin
		if (cycle_count % 256 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (cycle_count % 16) < 5;
		endcase
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk iff cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_LIMIT)
			cur_limit = val;
	endtask

	// The first wait lets a transfer at the current edge be counted before the queue is checked.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic apply_setting(logic [15:0] lim, logic [15:0] sup, logic [15:0] per);
		wait_drained();
		write_reg(REG_LIMIT, lim);
		write_reg(REG_SUPPLY, sup);
		write_reg(REG_PERIOD, per);
	endtask

	// Transfer one command; in_valid stays high so the caller may chain the next.
	task automatic send_command(logic [15:0] q, logic [15:0] d, logic [15:0] ang);
		in_valid <= 1'b1;
		volt_q <= q;
		volt_d <= d;
		elec_angle <= ang;
		@(posedge clk iff !in_stall);
	endtask

	function automatic logic [15:0] pick_volt();
		int sel;
		int span;
		sel = $urandom_range(0, 9);
		span = (cur_limit > 16'd30000) ? 32767 : cur_limit + cur_limit / 4 + 1;
		if (sel < 3)
			return 16'($urandom);
		else if (sel < 5)
			return 16'd0;
		else
			return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic random_burst_run(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0)
				burst = 1;
			for (int i = 0; i < burst && count > 0; i++) begin
				send_command(pick_volt(), pick_volt(), 16'($urandom));
				count--;
			end
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] dq [20] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
			16'h0400, 16'hFC00, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0C00,
			16'hF400, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00, 16'h0000, 16'h7FFF,
			16'h8000};
		logic [15:0] dd [20] = '{16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'h0400, 16'hFC00, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'h0000,
			16'h0000, 16'hAAAA, 16'h5555, 16'hFF00, 16'h0100, 16'hFFFF, 16'h8000,
			16'h7FFF};
		logic [15:0] da [20] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h2AAA, 16'h2AAB,
			16'h5555, 16'h8000, 16'hAAAA, 16'hD555, 16'h1234, 16'hFFFF, 16'h0000,
			16'h0000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8001, 16'hC000, 16'h0001,
			16'hEDCB};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a zero limit forces every duty to one half.
		for (int i = 0; i < 5; i++)
			send_command(dq[i], dd[i], da[i]);
		in_valid <= 1'b0;

		// Limit above supply, full-scale commands hit the index cap.
		apply_setting(16'hFFFF, 16'd3072, 16'd1000);
		for (int i = 0; i < 20; i++)
			send_command(dq[i], dd[i], da[i]);
		in_valid <= 1'b0;
		random_burst_run(150);

		apply_setting(16'd3000, 16'hFFFF, 16'hFFFF);
		random_burst_run(150);

		// Hold off until the pipeline has fully drained, then resume.
		wait_drained();
		random_burst_run(30);

		apply_setting(16'd700, 16'd1, 16'd1);
		random_burst_run(130);

		apply_setting(16'd2048, 16'd0, 16'd0);
		random_burst_run(100);

		apply_setting(16'd1, 16'd4096, 16'd20000);
		random_burst_run(130);

		apply_setting(16'd32767, 16'd32768, 16'd4095);
		random_burst_run(160);

		apply_setting(16'd2500, 16'd3072, 16'd1000);
		random_burst_run(175);

		wait_drained();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
src/svpd_pkg.sv
src/svpd_mag.sv
src/svpd_atan.sv
src/svpd_sin.sv
src/svpwm_phase_duty_core.sv
verif/svpd_checker.sv
verif/tb_top.sv
